/* hdl/uniform_circular_lbp_encoder_unit_defines.svh */
// Assertion macros for the LBP encoder checker.
`ifndef UNIFORM_CIRCULAR_LBP_ENCODER_UNIT_DEFINES_SVH
`define UNIFORM_CIRCULAR_LBP_ENCODER_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define LBP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define LBP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lbp_pkg.sv */
// Shared types, constants and the uniform pattern table of the LBP encoder.
`default_nettype none
package lbp_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_RADIUS_DEF = 4;
  localparam int NEIGHBORS      = 8;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QLVL_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int PADDR_W        = 4;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;
  localparam logic [1:0] REG_DIAG   = 2'd3;

  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [11:0] HEIGHT_RST = 12'd480;
  localparam logic [2:0]  RADIUS_RST = 3'd1;
  localparam logic [10:0] DIAG_RST   = 11'd181;

  // sample direction masks, bit k for neighbor k
  localparam logic [NEIGHBORS-1:0] ROW_PLUS  = 8'b1000_0011;
  localparam logic [NEIGHBORS-1:0] ROW_MINUS = 8'b0011_1000;
  localparam logic [NEIGHBORS-1:0] COL_PLUS  = 8'b1110_0000;
  localparam logic [NEIGHBORS-1:0] COL_MINUS = 8'b0000_1110;

  // per-sample window corners and Q16 bilinear weights
  typedef struct packed {
    logic [4:0]  ia0;
    logic [4:0]  ia1;
    logic [4:0]  ja0;
    logic [4:0]  ja1;
    logic [16:0] w00;
    logic [16:0] w01;
    logic [16:0] w10;
    logic [16:0] w11;
  } samp_t;

  typedef struct packed {
    logic [10:0] width;
    logic [11:0] height;
    logic [4:0]  twice_r;
    logic [4:0]  rad;
    samp_t [NEIGHBORS-1:0] samp;
  } cfg_t;

  typedef struct packed {
    logic [7:0] centre;
    logic [NEIGHBORS-1:0][3:0][7:0] pix;
    logic row_end;
    logic frame_end;
  } item_t;

  typedef logic [255:0][5:0] uni_tab_t;

  function automatic logic [3:0] hop_cnt(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i] != v[(i + 1) % 8]);
    end
    return n;
  endfunction

  function automatic uni_tab_t build_uni_tab();
    uni_tab_t t;
    logic [5:0] n;
    n = '0;
    for (int v = 0; v < 256; v++) begin
      if (hop_cnt(8'(v)) < 4'd3) begin
        n = n + 6'd1;
        t[v] = n;
      end else begin
        t[v] = '0;
      end
    end
    return t;
  endfunction

  localparam uni_tab_t UNI_TAB = build_uni_tab();

endpackage
`default_nettype wire

/* hdl/lbp_cfg.sv */
// Register file and derived sampling geometry of the LBP encoder.
`default_nettype none
module lbp_cfg #(
  parameter int MAX_WIDTH  = lbp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = lbp_pkg::MAX_RADIUS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [lbp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  output lbp_pkg::cfg_t cfg
);
  import lbp_pkg::*;

  logic [10:0] image_width, image_width_next;
  logic [11:0] image_height, image_height_next;
  logic [2:0]  radius, radius_next;
  logic [10:0] diag_offset, diag_offset_next;
  cfg_t        cfg_next;

  assign pready = 1'b1;

  always_comb begin
    image_width_next  = image_width;
    image_height_next = image_height;
    radius_next       = radius;
    diag_offset_next  = diag_offset;
    if (rst) begin
      image_width_next  = WIDTH_RST;
      image_height_next = HEIGHT_RST;
      radius_next       = RADIUS_RST;
      diag_offset_next  = DIAG_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_WIDTH:  image_width_next  = pwdata[10:0];
        REG_HEIGHT: image_height_next = pwdata[11:0];
        REG_RADIUS: radius_next       = pwdata[2:0];
        REG_DIAG:   diag_offset_next  = pwdata[10:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = {21'd0, image_width};
      REG_HEIGHT: prdata = {20'd0, image_height};
      REG_RADIUS: prdata = {29'd0, radius};
      REG_DIAG:   prdata = {21'd0, diag_offset};
    endcase
  end

  // clamp the raw values and work out corners and weights of each sample
  always_comb begin
    logic [3:0]  rad4;
    logic [11:0] base, dlim;
    logic [12:0] mag, pr, pc;
    logic [4:0]  r0, r1, c0, c1;
    logic [7:0]  fr, fc;
    logic [8:0]  ifr, ifc;
    logic [17:0] m;
    cfg_next.width = (image_width_next < 11'd3) ? 11'd3 :
                     (int'(image_width_next) > MAX_WIDTH) ? 11'(MAX_WIDTH) :
                     image_width_next;
    cfg_next.height = (image_height_next < 12'd3) ? 12'd3 : image_height_next;
    rad4 = (radius_next == 3'd0) ? 4'd1 :
           ({1'b0, radius_next} > 4'(MAX_RADIUS)) ? 4'(MAX_RADIUS) :
           {1'b0, radius_next};
    cfg_next.rad     = {1'b0, rad4};
    cfg_next.twice_r = {rad4, 1'b0};
    base = {rad4, 8'd0};
    dlim = ({1'b0, diag_offset_next} > base) ? base : {1'b0, diag_offset_next};
    for (int k = 0; k < NEIGHBORS; k++) begin
      mag = (k % 2 == 1) ? {1'b0, dlim} : {1'b0, base};
      pr  = ROW_PLUS[k]  ? {1'b0, base} + mag :
            ROW_MINUS[k] ? {1'b0, base} - mag : {1'b0, base};
      pc  = COL_PLUS[k]  ? {1'b0, base} + mag :
            COL_MINUS[k] ? {1'b0, base} - mag : {1'b0, base};
      r0 = pr[12:8];
      fr = pr[7:0];
      c0 = pc[12:8];
      fc = pc[7:0];
      r1 = (fr != 8'd0) ? r0 + 5'd1 : r0;
      c1 = (fc != 8'd0) ? c0 + 5'd1 : c0;
      cfg_next.samp[k].ia0 = cfg_next.twice_r - r0;
      cfg_next.samp[k].ia1 = cfg_next.twice_r - r1;
      cfg_next.samp[k].ja0 = cfg_next.twice_r - c0;
      cfg_next.samp[k].ja1 = cfg_next.twice_r - c1;
      ifr = 9'd256 - {1'b0, fr};
      ifc = 9'd256 - {1'b0, fc};
      m = ifr * ifc;
      cfg_next.samp[k].w00 = m[16:0];
      m = ifr * {1'b0, fc};
      cfg_next.samp[k].w01 = m[16:0];
      m = {1'b0, fr} * ifc;
      cfg_next.samp[k].w10 = m[16:0];
      m = {1'b0, fr} * {1'b0, fc};
      cfg_next.samp[k].w11 = m[16:0];
    end
  end

  always_ff @(posedge clk) begin
    image_width  <= image_width_next;
    image_height <= image_height_next;
    radius       <= radius_next;
    diag_offset  <= diag_offset_next;
    cfg          <= cfg_next;
  end

endmodule
`default_nettype wire

/* hdl/lbp_front.sv */
// Front end: raster counters, row banks, sliding window and sample gather.
`default_nettype none
module lbp_front #(
  parameter int MAX_WIDTH  = lbp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = lbp_pkg::MAX_RADIUS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] pixel,
  input  logic frame_start,
  input  lbp_pkg::cfg_t cfg,
  input  logic [lbp_pkg::QLVL_W-1:0] q_level,
  output logic push,
  output lbp_pkg::item_t item
);
  import lbp_pkg::*;

  localparam int WIN_ROWS = 2 * MAX_RADIUS + 1;
  localparam int BW       = $clog2(WIN_ROWS);
  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int CMPW     = ((CW > 11) ? CW : 11) + 1;

  logic [CW-1:0]   col, col_next, cur_c;
  logic [11:0]     row, row_next, cur_r;
  logic [12:0]     pre_r, r_inc;
  logic [CMPW-1:0] c_inc;
  logic [BW-1:0]   bank, bank_next, cur_b;
  logic            acc, emit, is_re, is_fe;

  logic [7:0] mem [WIN_ROWS][MAX_WIDTH];
  logic [7:0] rd [WIN_ROWS];
  logic [7:0] colv [WIN_ROWS];
  logic [7:0] win [WIN_ROWS][WIN_ROWS];

  logic          s1_v, s1_emit, s1_re, s1_fe;
  logic [7:0]    s1_pix;
  logic [BW-1:0] s1_bank;
  logic          s2_v, s2_re, s2_fe;
  logic [QLVL_W:0] occupancy;

  function automatic logic [BW-1:0] bank_inc(input logic [BW-1:0] b);
    return (b == BW'(WIN_ROWS - 1)) ? '0 : b + 1'b1;
  endfunction

  // room for everything in flight plus this beat
  assign occupancy = {1'b0, q_level} + (QLVL_W + 1)'(s1_v && s1_emit)
                   + (QLVL_W + 1)'(s2_v);
  assign in_stall  = occupancy >= (QLVL_W + 1)'(QUEUE_DEPTH);
  assign acc       = in_valid && !in_stall;

  // position of this pixel
  always_comb begin
    cur_c = frame_start ? '0 : col;
    pre_r = frame_start ? 13'd0 : {1'b0, row};
    cur_b = frame_start ? '0 : bank;
    if (CMPW'(cur_c) >= CMPW'(cfg.width)) begin
      cur_c = '0;
      pre_r = pre_r + 13'd1;
      cur_b = bank_inc(cur_b);
    end
    if (pre_r >= 13'(cfg.height)) begin
      pre_r = '0;
      cur_b = '0;
    end
    cur_r = pre_r[11:0];
  end

  assign emit  = ({1'b0, cur_r} >= 13'(cfg.twice_r)) &&
                 (CMPW'(cur_c) >= CMPW'(cfg.twice_r));
  assign is_re = (CMPW'(cur_c) + CMPW'(1)) == CMPW'(cfg.width);
  assign is_fe = is_re && (({1'b0, cur_r} + 13'd1) == 13'(cfg.height));

  always_comb begin
    c_inc = CMPW'(cur_c) + CMPW'(1);
    r_inc = {1'b0, cur_r} + 13'd1;
    if (c_inc >= CMPW'(cfg.width)) begin
      col_next = '0;
      if (r_inc >= 13'(cfg.height)) begin
        row_next  = '0;
        bank_next = '0;
      end else begin
        row_next  = r_inc[11:0];
        bank_next = bank_inc(cur_b);
      end
    end else begin
      col_next  = c_inc[CW-1:0];
      row_next  = cur_r;
      bank_next = cur_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      bank <= '0;
    end else if (acc) begin
      col  <= col_next;
      row  <= row_next;
      bank <= bank_next;
    end
  end

  // one bank per window row, all read at the current column
  always_ff @(posedge clk) begin
    if (acc) begin
      mem[cur_b][cur_c] <= pixel;
      for (int g = 0; g < WIN_ROWS; g++) begin
        rd[g] <= mem[g][cur_c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= acc;
      s2_v <= s1_v && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    s1_emit <= emit;
    s1_pix  <= pixel;
    s1_bank <= cur_b;
    s1_re   <= is_re;
    s1_fe   <= is_fe;
    s2_re   <= s1_re;
    s2_fe   <= s1_fe;
  end

  // new window column, row offset i above the current row
  always_comb begin
    logic [BW:0] sel;
    for (int i = 0; i < WIN_ROWS; i++) begin
      sel = {1'b0, s1_bank} + (BW + 1)'(WIN_ROWS - i);
      if (sel >= (BW + 1)'(WIN_ROWS)) begin
        sel = sel - (BW + 1)'(WIN_ROWS);
      end
      colv[i] = (i == 0) ? s1_pix : rd[sel[BW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v) begin
      for (int i = 0; i < WIN_ROWS; i++) begin
        win[i][0] <= colv[i];
        for (int j = 1; j < WIN_ROWS; j++) begin
          win[i][j] <= win[i][j-1];
        end
      end
    end
  end

  // gather the four corners of every sample
  always_comb begin
    item.centre    = win[cfg.rad[BW-1:0]][cfg.rad[BW-1:0]];
    item.row_end   = s2_re;
    item.frame_end = s2_fe;
    for (int k = 0; k < NEIGHBORS; k++) begin
      item.pix[k][0] = win[cfg.samp[k].ia0[BW-1:0]][cfg.samp[k].ja0[BW-1:0]];
      item.pix[k][1] = win[cfg.samp[k].ia0[BW-1:0]][cfg.samp[k].ja1[BW-1:0]];
      item.pix[k][2] = win[cfg.samp[k].ia1[BW-1:0]][cfg.samp[k].ja0[BW-1:0]];
      item.pix[k][3] = win[cfg.samp[k].ia1[BW-1:0]][cfg.samp[k].ja1[BW-1:0]];
    end
  end

  assign push = s2_v;

endmodule
`default_nettype wire

/* hdl/lbp_queue.sv */
// Short queue of gathered samples between front and back ends.
`default_nettype none
module lbp_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  lbp_pkg::item_t din,
  input  logic pop,
  output lbp_pkg::item_t dout,
  output logic empty,
  output logic [lbp_pkg::QLVL_W-1:0] level
);
  import lbp_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  item_t slots [QUEUE_DEPTH];
  logic [AW-1:0] wp, rp;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty = (level == '0);
  assign dout  = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      level <= '0;
    end else begin
      if (push) wp <= ptr_inc(wp);
      if (pop) rp <= ptr_inc(rp);
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/lbp_back.sv */
// Back end: bilinear products, threshold against centre, uniform mapping.
`default_nettype none
module lbp_back (
  input  logic clk,
  input  logic rst,
  input  lbp_pkg::cfg_t cfg,
  input  lbp_pkg::item_t head,
  input  logic empty,
  output logic pop,
  output logic out_valid,
  input  logic out_stall,
  output logic [5:0] lbp_code,
  output logic row_end,
  output logic frame_end
);
  import lbp_pkg::*;

  logic        en;
  logic        b1_v, b1_re, b1_fe;
  logic [7:0]  b1_centre;
  logic [24:0] prod [NEIGHBORS][4];
  logic        b2_v, b2_re, b2_fe;
  logic [7:0]  b2_pat, pat_c;

  assign en  = !out_valid || !out_stall;
  assign pop = en && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v      <= 1'b0;
      b2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b1_v      <= pop;
      b2_v      <= b1_v;
      out_valid <= b2_v;
    end
  end

  always_comb begin
    logic [24:0] sum;
    for (int k = 0; k < NEIGHBORS; k++) begin
      sum = prod[k][0] + prod[k][1] + prod[k][2] + prod[k][3];
      pat_c[NEIGHBORS-1-k] = sum > {1'b0, b1_centre, 16'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_centre <= head.centre;
      b1_re     <= head.row_end;
      b1_fe     <= head.frame_end;
      for (int k = 0; k < NEIGHBORS; k++) begin
        prod[k][0] <= 25'(head.pix[k][0]) * 25'(cfg.samp[k].w00);
        prod[k][1] <= 25'(head.pix[k][1]) * 25'(cfg.samp[k].w01);
        prod[k][2] <= 25'(head.pix[k][2]) * 25'(cfg.samp[k].w10);
        prod[k][3] <= 25'(head.pix[k][3]) * 25'(cfg.samp[k].w11);
      end
      b2_pat    <= pat_c;
      b2_re     <= b1_re;
      b2_fe     <= b1_fe;
      lbp_code  <= UNI_TAB[b2_pat];
      row_end   <= b2_re;
      frame_end <= b2_fe;
    end
  end

endmodule
`default_nettype wire

/* hdl/uniform_circular_lbp_encoder_unit.sv */
// Top level of the uniform circular LBP encoder.
// Takes one 8-bit grey pixel per clock (unless in_stall) in raster order and
// returns one 6-bit uniform LBP code per interior pixel (0 for non-uniform
// patterns), flagged with row_end / frame_end. Border pixels (first 2R rows
// and columns of the frame) give no beat. Sustained rate is one pixel per
// cycle while in_stall is low; it is set by the row banks, which take one
// write and one read per bank per cycle. A code passes the front sample and
// window registers, the queue and the back product, pattern and output
// registers. The row store is 2*MAX_RADIUS+1 banks of MAX_WIDTH bytes, has no
// reset and needs no clearing pass; a 4-deep queue decouples the front from
// the back, and in_stall rises only when that queue plus what is in flight
// could fill it. Registers (APB, byte addresses): 0x0 image_width, 0x4
// image_height, 0x8 radius, 0xC diag_offset_q8; they take effect in the cycle
// after the write. The user must change them only while idle (not enforced).
`default_nettype none
module uniform_circular_lbp_encoder_unit #(
  parameter int MAX_WIDTH  = lbp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = lbp_pkg::MAX_RADIUS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] pixel,
  input  logic frame_start,
  output logic out_valid,
  input  logic out_stall,
  output logic [5:0] lbp_code,
  output logic row_end,
  output logic frame_end,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [lbp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import lbp_pkg::*;

  cfg_t  cfg;
  item_t q_din, q_dout;
  logic  q_push, q_pop, q_empty;
  logic [QLVL_W-1:0] q_level;

  // register file, clamps and per-sample geometry
  lbp_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // front: counters, row banks, window, gather
  lbp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel       (pixel),
    .frame_start (frame_start),
    .cfg         (cfg),
    .q_level     (q_level),
    .push        (q_push),
    .item        (q_din)
  );

  lbp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .level (q_level)
  );

  // back: weights x corners, compare, table, output register
  lbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (q_dout),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .lbp_code  (lbp_code),
    .row_end   (row_end),
    .frame_end (frame_end)
  );

endmodule
`default_nettype wire

/* hdl/lbp_checker.sv */
// Port-level checker for the LBP encoder, bound to the top level.
`default_nettype none
`include "uniform_circular_lbp_encoder_unit_defines.svh"
module lbp_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic [5:0] lbp_code,
  input logic row_end,
  input logic frame_end
);

  `LBP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(lbp_code) && $stable(row_end) && $stable(frame_end), "stalled output beat changed")
  `LBP_ASSERT_IMP(a_code_range, out_valid, lbp_code <= 6'd58, "code beyond uniform range")
  `LBP_ASSERT_IMP(a_frame_row, out_valid && frame_end, row_end, "frame end without row end")
  `LBP_ASSERT_IMP(a_reset_quiet, $fell(rst), !out_valid, "output beat right after reset")

endmodule

bind uniform_circular_lbp_encoder_unit lbp_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .lbp_code  (lbp_code),
  .row_end   (row_end),
  .frame_end (frame_end)
);
`default_nettype wire
